// ===== design/bptc_pkg.sv =====
// Shared widths, stage numbering, register codes and types of the barometric compensation block.
package bptc_pkg;

    // Number of register stages from input beat to output register.
    localparam int NSTG = 9;

    // Stage numbering, input side first.
    localparam int ST_DT   = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_LIN  = 2;
    localparam int ST_SQR  = 3;
    localparam int ST_CORR = 4;
    localparam int ST_FIN  = 5;
    localparam int ST_PP   = 6;
    localparam int ST_SUM  = 7;
    localparam int ST_OUT  = 8;

    // Field and calibration widths.
    localparam int W_RAW     = 24;
    localparam int W_CAL     = 16;
    localparam int W_CFG_IDX = 3;
    localparam int W_TOUT    = 18;
    localparam int W_POUT    = 24;

    // Internal datapath widths, all signed unless stated.
    localparam int W_DT   = W_RAW + 1;        // raw temperature minus reference
    localparam int W_PROD = W_DT + W_CAL + 1; // dT times a calibration word
    localparam int W_SQ   = 2 * W_DT;         // dT squared
    localparam int W_TEMP = 20;               // first-order temperature
    localparam int W_T2   = 19;               // second-order temperature term
    localparam int W_OFF  = 36;               // first-order offset
    localparam int W_SENS = 35;               // first-order sensitivity
    localparam int W_SQR  = 35;               // unsigned temperature squares
    localparam int W_CORR = 38;               // unsigned second-order corrections
    localparam int W_FIN  = 40;               // corrected offset and sensitivity
    localparam int W_SPLIT = 20;              // low part of the split sensitivity multiply

    // Shift amounts of the fixed-point scaling.
    localparam int TEMP_SH = 23;
    localparam int OFF_SH  = 7;
    localparam int SENS_SH = 8;
    localparam int T2_SH   = 31;
    localparam int PROD_SH = 21;
    localparam int PRES_SH = 15;
    localparam int C2_SH   = 16;
    localparam int C1_SH   = 15;
    localparam int C5_SH   = 8;

    // Temperature thresholds in hundredths of a degree.
    localparam int T_REF = 2000;
    localparam int T_LOW = -1500;

    // Calibration register indexes.
    typedef enum logic [W_CFG_IDX-1:0] {
        CAL_C1 = 3'd0,
        CAL_C2 = 3'd1,
        CAL_C3 = 3'd2,
        CAL_C4 = 3'd3,
        CAL_C5 = 3'd4,
        CAL_C6 = 3'd5
    } t_cal_idx;

    // Calibration words as held by the top level.
    typedef struct packed {
        logic [W_CAL-1:0] c1;
        logic [W_CAL-1:0] c2;
        logic [W_CAL-1:0] c3;
        logic [W_CAL-1:0] c4;
        logic [W_CAL-1:0] c5;
        logic [W_CAL-1:0] c6;
    } t_cal;

    // Per-stage load enables from the pipeline control.
    typedef struct packed {
        logic [NSTG-1:0] en;
    } t_pipe_en;

endpackage

// ===== design/bptc_pipe_ctrl.sv =====
// Valid bits and stall-aware load enables of the compensation pipeline.
module bptc_pipe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bptc_pkg::t_pipe_en  o_ctl
);

    logic [bptc_pkg::NSTG-1:0] r_vld;
    logic [bptc_pkg::NSTG-1:0] n_vld;
    logic [bptc_pkg::NSTG-1:0] en;
    logic [bptc_pkg::NSTG-1:0] vld_src;
    logic                      in_beat;
    logic                      out_beat;

    // A stage loads when it is empty or when the stage after it loads, so bubbles collapse.
    always_comb begin
        en[bptc_pkg::NSTG-1] = !r_vld[bptc_pkg::NSTG-1] || i_out_ready;
        for (int k = bptc_pkg::NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    // Each loading stage takes the valid bit of the stage before it.
    always_comb begin
        vld_src = {r_vld[bptc_pkg::NSTG-2:0], i_in_valid};
        n_vld   = r_vld;
        for (int k = 0; k < bptc_pkg::NSTG; k++) begin
            if (en[k]) begin
                n_vld[k] = vld_src[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[bptc_pkg::NSTG-1];
    assign o_ctl.en    = en;
    assign in_beat     = i_in_valid && en[0];
    assign out_beat    = r_vld[bptc_pkg::NSTG-1] && i_out_ready;

    // An accepted beat occupies the first stage in the next cycle.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> r_vld[0])
        else $error("accepted beat did not enter the first stage");

    // The input is only held off when the output itself is stalled.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_vld[bptc_pkg::NSTG-1] || i_out_ready) |-> o_in_ready)
        else $error("input stalled while the output side was free");

    // Items in flight change only by beats accepted and beats delivered.
    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ($countones(r_vld) ==
            $past($countones(r_vld)) + $past(in_beat) - $past(out_beat)))
        else $error("item lost or duplicated inside the pipeline");

endmodule

// ===== design/bptc_front.sv =====
// First-order stages: dT, the calibration products and the linear temperature, offset, sensitivity.
module bptc_front (
    input  logic                                 i_clk,
    input  bptc_pkg::t_pipe_en                   i_ctl,
    input  bptc_pkg::t_cal                       i_cal,
    input  logic        [bptc_pkg::W_RAW-1:0]    i_raw_pressure,
    input  logic        [bptc_pkg::W_RAW-1:0]    i_raw_temperature,
    output logic        [bptc_pkg::W_RAW-1:0]    o_d1,
    output logic signed [bptc_pkg::W_TEMP-1:0]   o_temp,
    output logic signed [bptc_pkg::W_T2-1:0]     o_t2,
    output logic signed [bptc_pkg::W_OFF-1:0]    o_off,
    output logic signed [bptc_pkg::W_SENS-1:0]   o_sens
);

    localparam int W_OFF_PAD  = bptc_pkg::W_OFF - bptc_pkg::W_CAL - bptc_pkg::C2_SH;
    localparam int W_SENS_PAD = bptc_pkg::W_SENS - bptc_pkg::W_CAL - bptc_pkg::C1_SH;

    logic        [bptc_pkg::W_RAW-1:0]  r_d1_s1;
    logic signed [bptc_pkg::W_DT-1:0]   r_dt_s1;
    logic signed [bptc_pkg::W_DT-1:0]   n_dt;

    logic        [bptc_pkg::W_RAW-1:0]  r_d1_s2;
    logic signed [bptc_pkg::W_PROD-1:0] r_p_tc;
    logic signed [bptc_pkg::W_PROD-1:0] r_p_off;
    logic signed [bptc_pkg::W_PROD-1:0] r_p_sens;
    logic signed [bptc_pkg::W_SQ-1:0]   r_p_sq;
    logic signed [bptc_pkg::W_PROD-1:0] n_p_tc;
    logic signed [bptc_pkg::W_PROD-1:0] n_p_off;
    logic signed [bptc_pkg::W_PROD-1:0] n_p_sens;
    logic signed [bptc_pkg::W_SQ-1:0]   n_p_sq;

    logic        [bptc_pkg::W_RAW-1:0]  r_d1_s3;
    logic signed [bptc_pkg::W_TEMP-1:0] r_temp;
    logic signed [bptc_pkg::W_T2-1:0]   r_t2;
    logic signed [bptc_pkg::W_OFF-1:0]  r_off;
    logic signed [bptc_pkg::W_SENS-1:0] r_sens;
    logic signed [bptc_pkg::W_TEMP-1:0] n_temp;
    logic signed [bptc_pkg::W_T2-1:0]   n_t2;
    logic signed [bptc_pkg::W_OFF-1:0]  n_off;
    logic signed [bptc_pkg::W_SENS-1:0] n_sens;

    // Stage one: difference between the raw temperature and the reference reading.
    assign n_dt = $signed({1'b0, i_raw_temperature})
                - $signed({1'b0, i_cal.c5, {bptc_pkg::C5_SH{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[bptc_pkg::ST_DT]) begin
            r_d1_s1 <= i_raw_pressure;
            r_dt_s1 <= n_dt;
        end
    end

    // Stage two: the four products of dT, all calibration words taken as positive.
    always_comb begin
        n_p_tc   = r_dt_s1 * $signed({1'b0, i_cal.c6});
        n_p_off  = r_dt_s1 * $signed({1'b0, i_cal.c4});
        n_p_sens = r_dt_s1 * $signed({1'b0, i_cal.c3});
        n_p_sq   = r_dt_s1 * r_dt_s1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[bptc_pkg::ST_MUL]) begin
            r_d1_s2  <= r_d1_s1;
            r_p_tc   <= n_p_tc;
            r_p_off  <= n_p_off;
            r_p_sens <= n_p_sens;
            r_p_sq   <= n_p_sq;
        end
    end

    // Stage three: scale the products by arithmetic shifts and add the constant terms.
    always_comb begin
        n_temp = $signed(r_p_tc[bptc_pkg::W_PROD-1:bptc_pkg::TEMP_SH])
               + bptc_pkg::W_TEMP'(bptc_pkg::T_REF);
        n_off  = $signed({{W_OFF_PAD{1'b0}}, i_cal.c2, {bptc_pkg::C2_SH{1'b0}}})
               + $signed(r_p_off[bptc_pkg::W_PROD-1:bptc_pkg::OFF_SH]);
        n_sens = $signed({{W_SENS_PAD{1'b0}}, i_cal.c1, {bptc_pkg::C1_SH{1'b0}}})
               + $signed(r_p_sens[bptc_pkg::W_PROD-1:bptc_pkg::SENS_SH]);
        n_t2   = $signed(r_p_sq[bptc_pkg::W_SQ-1:bptc_pkg::T2_SH]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[bptc_pkg::ST_LIN]) begin
            r_d1_s3 <= r_d1_s2;
            r_temp  <= n_temp;
            r_t2    <= n_t2;
            r_off   <= n_off;
            r_sens  <= n_sens;
        end
    end

    assign o_d1   = r_d1_s3;
    assign o_temp = r_temp;
    assign o_t2   = r_t2;
    assign o_off  = r_off;
    assign o_sens = r_sens;

endmodule

// ===== design/bptc_second.sv =====
// Second-order stages: cold-range corrections and the final offset and sensitivity.
module bptc_second (
    input  logic                                 i_clk,
    input  bptc_pkg::t_pipe_en                   i_ctl,
    input  logic        [bptc_pkg::W_RAW-1:0]    i_d1,
    input  logic signed [bptc_pkg::W_TEMP-1:0]   i_temp,
    input  logic signed [bptc_pkg::W_T2-1:0]     i_t2,
    input  logic signed [bptc_pkg::W_OFF-1:0]    i_off,
    input  logic signed [bptc_pkg::W_SENS-1:0]   i_sens,
    output logic        [bptc_pkg::W_RAW-1:0]    o_d1,
    output logic signed [bptc_pkg::W_TOUT-1:0]   o_tout,
    output logic signed [bptc_pkg::W_FIN-1:0]    o_off_fin,
    output logic signed [bptc_pkg::W_FIN-1:0]    o_sens_fin
);

    localparam int W_WIDE   = bptc_pkg::W_SQR + 5;
    localparam int W_SQFULL = 2 * bptc_pkg::W_TEMP;
    localparam int TOUT_MAX = 2 ** (bptc_pkg::W_TOUT - 1) - 1;
    localparam int TOUT_MIN = -(2 ** (bptc_pkg::W_TOUT - 1));

    // Stage four signals.
    logic signed [bptc_pkg::W_TEMP-1:0] n_dta;
    logic signed [bptc_pkg::W_TEMP-1:0] n_dtb;
    logic signed [W_SQFULL-1:0]         n_sq_a;
    logic signed [W_SQFULL-1:0]         n_sq_b;
    logic signed [bptc_pkg::W_TEMP-1:0] n_tdiff;
    logic signed [bptc_pkg::W_TOUT-1:0] n_tout;
    logic                               n_low;
    logic                               n_vlow;

    logic        [bptc_pkg::W_RAW-1:0]  r_d1_s4;
    logic signed [bptc_pkg::W_TOUT-1:0] r_tout_s4;
    logic signed [bptc_pkg::W_OFF-1:0]  r_off_s4;
    logic signed [bptc_pkg::W_SENS-1:0] r_sens_s4;
    logic        [bptc_pkg::W_SQR-1:0]  r_sq_a;
    logic        [bptc_pkg::W_SQR-1:0]  r_sq_b;
    logic                               r_low;
    logic                               r_vlow;

    // Stage five signals.
    logic        [W_WIDE-1:0]           a_ext;
    logic        [W_WIDE-1:0]           b_ext;
    logic        [W_WIDE-1:0]           a5;
    logic        [W_WIDE-1:0]           b7;
    logic        [W_WIDE-1:0]           b11;
    logic        [W_WIDE-1:0]           off2_sum;
    logic        [W_WIDE-1:0]           sens2_sum;
    logic        [bptc_pkg::W_CORR-1:0] n_off2;
    logic        [bptc_pkg::W_CORR-1:0] n_sens2;

    logic        [bptc_pkg::W_RAW-1:0]  r_d1_s5;
    logic signed [bptc_pkg::W_TOUT-1:0] r_tout_s5;
    logic signed [bptc_pkg::W_OFF-1:0]  r_off_s5;
    logic signed [bptc_pkg::W_SENS-1:0] r_sens_s5;
    logic        [bptc_pkg::W_CORR-1:0] r_off2;
    logic        [bptc_pkg::W_CORR-1:0] r_sens2;

    // Stage six signals.
    logic signed [bptc_pkg::W_FIN-1:0]  n_off_fin;
    logic signed [bptc_pkg::W_FIN-1:0]  n_sens_fin;

    logic        [bptc_pkg::W_RAW-1:0]  r_d1_s6;
    logic signed [bptc_pkg::W_TOUT-1:0] r_tout_s6;
    logic signed [bptc_pkg::W_FIN-1:0]  r_off_fin;
    logic signed [bptc_pkg::W_FIN-1:0]  r_sens_fin;

    // Stage four: range flags, the two temperature squares and the saturated temperature.
    always_comb begin
        n_dta   = i_temp - bptc_pkg::W_TEMP'(bptc_pkg::T_REF);
        n_dtb   = i_temp - bptc_pkg::W_TEMP'(bptc_pkg::T_LOW);
        n_sq_a  = n_dta * n_dta;
        n_sq_b  = n_dtb * n_dtb;
        n_low   = i_temp < bptc_pkg::W_TEMP'(bptc_pkg::T_REF);
        n_vlow  = i_temp < bptc_pkg::W_TEMP'(bptc_pkg::T_LOW);
        // The second-order temperature term only applies below the reference temperature.
        if (n_low) begin
            n_tdiff = i_temp - bptc_pkg::W_TEMP'(i_t2);
        end else begin
            n_tdiff = i_temp;
        end
        if (n_tdiff > bptc_pkg::W_TEMP'(TOUT_MAX)) begin
            n_tout = bptc_pkg::W_TOUT'(TOUT_MAX);
        end else if (n_tdiff < bptc_pkg::W_TEMP'(TOUT_MIN)) begin
            n_tout = bptc_pkg::W_TOUT'(TOUT_MIN);
        end else begin
            n_tout = n_tdiff[bptc_pkg::W_TOUT-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[bptc_pkg::ST_SQR]) begin
            r_d1_s4   <= i_d1;
            r_tout_s4 <= n_tout;
            r_off_s4  <= i_off;
            r_sens_s4 <= i_sens;
            r_sq_a    <= n_sq_a[bptc_pkg::W_SQR-1:0];
            r_sq_b    <= n_sq_b[bptc_pkg::W_SQR-1:0];
            r_low     <= n_low;
            r_vlow    <= n_vlow;
        end
    end

    // Stage five: the offset and sensitivity corrections, by shifts and adds only.
    // The squares are non-negative, so the arithmetic shifts are plain right shifts.
    always_comb begin
        a_ext     = {5'b0, r_sq_a};
        b_ext     = {5'b0, r_sq_b};
        a5        = (a_ext << 2) + a_ext;
        b7        = (b_ext << 3) - b_ext;
        b11       = (b_ext << 3) + (b_ext << 1) + b_ext;
        off2_sum  = '0;
        sens2_sum = '0;
        if (r_low) begin
            off2_sum  = a5 >> 1;
            sens2_sum = a5 >> 2;
            if (r_vlow) begin
                off2_sum  = off2_sum + b7;
                sens2_sum = sens2_sum + (b11 >> 1);
            end
        end
        n_off2  = off2_sum[bptc_pkg::W_CORR-1:0];
        n_sens2 = sens2_sum[bptc_pkg::W_CORR-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[bptc_pkg::ST_CORR]) begin
            r_d1_s5   <= r_d1_s4;
            r_tout_s5 <= r_tout_s4;
            r_off_s5  <= r_off_s4;
            r_sens_s5 <= r_sens_s4;
            r_off2    <= n_off2;
            r_sens2   <= n_sens2;
        end
    end

    // Stage six: apply the corrections.
    always_comb begin
        n_off_fin  = bptc_pkg::W_FIN'(r_off_s5)
                   - $signed({{(bptc_pkg::W_FIN - bptc_pkg::W_CORR){1'b0}}, r_off2});
        n_sens_fin = bptc_pkg::W_FIN'(r_sens_s5)
                   - $signed({{(bptc_pkg::W_FIN - bptc_pkg::W_CORR){1'b0}}, r_sens2});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[bptc_pkg::ST_FIN]) begin
            r_d1_s6    <= r_d1_s5;
            r_tout_s6  <= r_tout_s5;
            r_off_fin  <= n_off_fin;
            r_sens_fin <= n_sens_fin;
        end
    end

    assign o_d1       = r_d1_s6;
    assign o_tout     = r_tout_s6;
    assign o_off_fin  = r_off_fin;
    assign o_sens_fin = r_sens_fin;

endmodule

// ===== design/bptc_press.sv =====
// Pressure stages: split sensitivity multiply, recombination, offset removal and output register.
module bptc_press (
    input  logic                                 i_clk,
    input  bptc_pkg::t_pipe_en                   i_ctl,
    input  logic        [bptc_pkg::W_RAW-1:0]    i_d1,
    input  logic signed [bptc_pkg::W_TOUT-1:0]   i_tout,
    input  logic signed [bptc_pkg::W_FIN-1:0]    i_off_fin,
    input  logic signed [bptc_pkg::W_FIN-1:0]    i_sens_fin,
    output logic signed [bptc_pkg::W_TOUT-1:0]   o_temperature,
    output logic signed [bptc_pkg::W_POUT-1:0]   o_pressure
);

    localparam int W_PL   = bptc_pkg::W_RAW + bptc_pkg::W_SPLIT;
    localparam int W_PH   = bptc_pkg::W_RAW + 1 + bptc_pkg::W_FIN - bptc_pkg::W_SPLIT;
    localparam int W_PRD  = W_PH + bptc_pkg::W_SPLIT;
    localparam int W_Q    = W_PRD - bptc_pkg::PROD_SH;
    localparam int W_DIFF = W_Q + 1;
    localparam int W_SH   = W_DIFF - bptc_pkg::PRES_SH;
    localparam int P_MAX  = 2 ** (bptc_pkg::W_POUT - 1) - 1;
    localparam int P_MIN  = -(2 ** (bptc_pkg::W_POUT - 1));

    logic        [W_PL-1:0]             n_pl;
    logic signed [W_PH-1:0]             n_ph;
    logic        [W_PL-1:0]             r_pl;
    logic signed [W_PH-1:0]             r_ph;
    logic signed [bptc_pkg::W_FIN-1:0]  r_off_s7;
    logic signed [bptc_pkg::W_TOUT-1:0] r_tout_s7;

    logic signed [W_PRD-1:0]            n_prod;
    logic signed [W_Q-1:0]              r_q;
    logic signed [bptc_pkg::W_FIN-1:0]  r_off_s8;
    logic signed [bptc_pkg::W_TOUT-1:0] r_tout_s8;

    logic signed [W_DIFF-1:0]           n_diff;
    logic signed [W_SH-1:0]             n_scaled;
    logic signed [bptc_pkg::W_POUT-1:0] n_pres;
    logic signed [bptc_pkg::W_POUT-1:0] r_pres;
    logic signed [bptc_pkg::W_TOUT-1:0] r_tout_s9;

    // Stage seven: D1 times the low and high parts of the sensitivity.
    always_comb begin
        n_pl = i_d1 * i_sens_fin[bptc_pkg::W_SPLIT-1:0];
        n_ph = $signed({1'b0, i_d1})
             * $signed(i_sens_fin[bptc_pkg::W_FIN-1:bptc_pkg::W_SPLIT]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[bptc_pkg::ST_PP]) begin
            r_pl      <= n_pl;
            r_ph      <= n_ph;
            r_off_s7  <= i_off_fin;
            r_tout_s7 <= i_tout;
        end
    end

    // Stage eight: recombine the partial products and scale down.
    assign n_prod = $signed({r_ph, {bptc_pkg::W_SPLIT{1'b0}}})
                  + $signed({{(W_PRD - W_PL){1'b0}}, r_pl});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[bptc_pkg::ST_SUM]) begin
            r_q       <= n_prod[W_PRD-1:bptc_pkg::PROD_SH];
            r_off_s8  <= r_off_s7;
            r_tout_s8 <= r_tout_s7;
        end
    end

    // Stage nine: remove the offset, scale to pascals and saturate into the output register.
    always_comb begin
        n_diff   = W_DIFF'(r_q) - W_DIFF'(r_off_s8);
        n_scaled = n_diff[W_DIFF-1:bptc_pkg::PRES_SH];
        if (n_scaled > W_SH'(P_MAX)) begin
            n_pres = bptc_pkg::W_POUT'(P_MAX);
        end else if (n_scaled < W_SH'(P_MIN)) begin
            n_pres = bptc_pkg::W_POUT'(P_MIN);
        end else begin
            n_pres = n_scaled[bptc_pkg::W_POUT-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[bptc_pkg::ST_OUT]) begin
            r_pres    <= n_pres;
            r_tout_s9 <= r_tout_s8;
        end
    end

    assign o_temperature = r_tout_s9;
    assign o_pressure    = r_pres;

endmodule

// ===== design/baro_pressure_temp_compensation_top.sv =====
// Top level of the barometric pressure and temperature compensation pipeline.
//
// Usage: one input beat carries a raw pressure conversion and a raw temperature
// conversion on i_raw_pressure and i_raw_temperature, qualified by i_in_valid and
// o_in_ready. One output beat per input beat carries the temperature in hundredths
// of a degree and the pressure in pascals, both saturated two's complement, on
// o_out_valid and i_out_ready, in the order the inputs arrived.
// The user writes the six calibration words through i_cfg_we, i_cfg_index and
// i_cfg_data only while no reading is in flight; the block itself does not enforce
// this. Indexes past the last word are ignored. Each reading passes through the nine
// register stages of the datapath (linear terms, squares, corrections, and a split
// multiply for the pressure) before o_out_valid rises.
// Throughput is one reading pair every cycle while the receiver does not stall.
// When the receiver stalls, items close up behind the output register and
// o_in_ready stays high until every stage holds an item.
// Synchronous reset clears all valid bits and sets every calibration word to zero.
module baro_pressure_temp_compensation_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic        [bptc_pkg::W_CFG_IDX-1:0] i_cfg_index,
    input  logic        [bptc_pkg::W_CAL-1:0]     i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic        [bptc_pkg::W_RAW-1:0]     i_raw_pressure,
    input  logic        [bptc_pkg::W_RAW-1:0]     i_raw_temperature,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [bptc_pkg::W_TOUT-1:0]    o_temperature,
    output logic signed [bptc_pkg::W_POUT-1:0]    o_pressure
);

    bptc_pkg::t_cal                       r_cal;
    bptc_pkg::t_pipe_en                   ctl;

    logic        [bptc_pkg::W_RAW-1:0]    fr_d1;
    logic signed [bptc_pkg::W_TEMP-1:0]   fr_temp;
    logic signed [bptc_pkg::W_T2-1:0]     fr_t2;
    logic signed [bptc_pkg::W_OFF-1:0]    fr_off;
    logic signed [bptc_pkg::W_SENS-1:0]   fr_sens;

    logic        [bptc_pkg::W_RAW-1:0]    sc_d1;
    logic signed [bptc_pkg::W_TOUT-1:0]   sc_tout;
    logic signed [bptc_pkg::W_FIN-1:0]    sc_off_fin;
    logic signed [bptc_pkg::W_FIN-1:0]    sc_sens_fin;

    // Calibration words; writes to unused indexes change nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bptc_pkg::CAL_C1: r_cal.c1 <= i_cfg_data;
                bptc_pkg::CAL_C2: r_cal.c2 <= i_cfg_data;
                bptc_pkg::CAL_C3: r_cal.c3 <= i_cfg_data;
                bptc_pkg::CAL_C4: r_cal.c4 <= i_cfg_data;
                bptc_pkg::CAL_C5: r_cal.c5 <= i_cfg_data;
                bptc_pkg::CAL_C6: r_cal.c6 <= i_cfg_data;
                default:          r_cal    <= r_cal;
            endcase
        end
    end

    // Valid bits and per-stage load enables.
    bptc_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl)
    );

    // First-order terms.
    bptc_front u_front (
        .i_clk             (i_clk),
        .i_ctl             (ctl),
        .i_cal             (r_cal),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_d1              (fr_d1),
        .o_temp            (fr_temp),
        .o_t2              (fr_t2),
        .o_off             (fr_off),
        .o_sens            (fr_sens)
    );

    // Second-order corrections.
    bptc_second u_second (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_d1       (fr_d1),
        .i_temp     (fr_temp),
        .i_t2       (fr_t2),
        .i_off      (fr_off),
        .i_sens     (fr_sens),
        .o_d1       (sc_d1),
        .o_tout     (sc_tout),
        .o_off_fin  (sc_off_fin),
        .o_sens_fin (sc_sens_fin)
    );

    // Pressure computation and output register.
    bptc_press u_press (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_d1          (sc_d1),
        .i_tout        (sc_tout),
        .i_off_fin     (sc_off_fin),
        .i_sens_fin    (sc_sens_fin),
        .o_temperature (o_temperature),
        .o_pressure    (o_pressure)
    );

endmodule
